FILE: src/crp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crp_pkg
// Shared widths, constants and types of the Catmull-Rom point evaluator.
// ----------------------------------------------------------------------------
package crp_pkg;

  localparam int COORD_W = 32;          // Q16.16 coordinate
  localparam int T_W     = 17;          // unsigned Q1.16 parameter, 65536 = 1.0
  localparam int H_W     = 19;          // signed Q.16 basis weight
  localparam int DIFF_W  = COORD_W + 1; // doubled point or point difference
  localparam int PROD_W  = DIFF_W + H_W;
  localparam int ACC_W   = PROD_W + 2;
  localparam int FRAC_SH = 17;          // Q.33 accumulator down to Q.16
  localparam int RND_W   = ACC_W - FRAC_SH;

  localparam logic [T_W-1:0] T_ONE = T_W'(65536);

  // Weight unit: stages from acceptance to registered weights.
  localparam int W_LAT   = 6;
  // Lane: multiply, pair add, final add and round, saturate.
  localparam int L_LAT   = W_LAT + 4;
  // Output register after the merge.
  localparam int OUT_LAT = L_LAT + 1;

  typedef struct packed {
    logic signed [H_W-1:0] h1;
    logic signed [H_W-1:0] h2;
    logic signed [H_W-1:0] h3;
    logic signed [H_W-1:0] h4;
  } weights_t;

  typedef struct packed {
    logic signed [DIFF_W-1:0] a2;   // 2*start
    logic signed [DIFF_W-1:0] b2;   // 2*end
    logic signed [DIFF_W-1:0] d0;   // end - prev
    logic signed [DIFF_W-1:0] d1;   // after - start
  } terms_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] coord;
    logic                      clip;
  } lane_res_t;

endpackage

FILE: src/crp_weights.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crp_weights
// Pipelined Hermite basis weights from t: square, cube, then four weights.
// ----------------------------------------------------------------------------
module crp_weights (
  input  logic                      clk_i,
  input  logic [crp_pkg::T_W-1:0]   param_t_i,
  output crp_pkg::weights_t         weights_o
);

  localparam int TW = crp_pkg::T_W;
  localparam int PW = 2 * TW;

  logic [TW-1:0] t_q, t1_q, t2d_q, t3d_q, t4d_q;
  logic [PW-1:0] sq_q, cu_q;
  logic [TW-1:0] sqr_q, sqr3_q, sqr4_q, cub_q;
  logic [PW-1:0] sq_rnd, cu_rnd;
  logic signed [crp_pkg::H_W:0] ts, t2s, t3s;
  logic signed [crp_pkg::H_W:0] h1w, h2w, h3w, h4w;
  crp_pkg::weights_t weights_q;

  assign sq_rnd = sq_q + PW'(32768);
  assign cu_rnd = cu_q + PW'(32768);

  assign ts  = $signed({2'b00, t4d_q});
  assign t2s = $signed({2'b00, sqr4_q});
  assign t3s = $signed({2'b00, cub_q});

  assign h1w = (t3s <<< 1) - (t2s + (t2s <<< 1)) + $signed((crp_pkg::H_W+1)'(65536));
  assign h2w = (t2s + (t2s <<< 1)) - (t3s <<< 1);
  assign h3w = t3s - (t2s <<< 1) + ts;
  assign h4w = t3s - t2s;

  always_ff @(posedge clk_i) begin
    // clamp t above one
    t_q       <= (param_t_i > crp_pkg::T_ONE) ? crp_pkg::T_ONE : param_t_i;
    sq_q      <= PW'(t_q) * PW'(t_q);
    t1_q      <= t_q;
    sqr_q     <= sq_rnd[TW+15:16];
    t2d_q     <= t1_q;
    cu_q      <= PW'(sqr_q) * PW'(t2d_q);
    sqr3_q    <= sqr_q;
    t3d_q     <= t2d_q;
    cub_q     <= cu_rnd[TW+15:16];
    sqr4_q    <= sqr3_q;
    t4d_q     <= t3d_q;
    weights_q <= '{h1: h1w[crp_pkg::H_W-1:0], h2: h2w[crp_pkg::H_W-1:0],
                   h3: h3w[crp_pkg::H_W-1:0], h4: h4w[crp_pkg::H_W-1:0]};
  end

  // sqr4_q, cub_q and t4d_q all line up one stage before weights_q
  assign weights_o = weights_q;

endmodule

FILE: src/crp_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crp_lane
// One coordinate lane: tangent terms, four products, sum, round, saturate.
// ----------------------------------------------------------------------------
module crp_lane (
  input  logic                               clk_i,
  input  logic signed [crp_pkg::COORD_W-1:0] prev_i,
  input  logic signed [crp_pkg::COORD_W-1:0] start_i,
  input  logic signed [crp_pkg::COORD_W-1:0] end_i,
  input  logic signed [crp_pkg::COORD_W-1:0] after_i,
  input  crp_pkg::weights_t                  weights_i,
  output crp_pkg::lane_res_t                 res_o
);

  localparam int DW = crp_pkg::DIFF_W;
  localparam int CW = crp_pkg::COORD_W;

  crp_pkg::terms_t terms_d;
  crp_pkg::terms_t dly_q [crp_pkg::W_LAT];
  crp_pkg::terms_t cur;

  logic signed [crp_pkg::PROD_W-1:0] p1_q, p2_q, p3_q, p4_q;
  logic signed [crp_pkg::ACC_W-1:0]  s01_q, s23_q, acc, biased;
  logic signed [crp_pkg::RND_W-1:0]  rnd_q;
  logic                              over;
  crp_pkg::lane_res_t                res_q, res_d;

  assign terms_d.a2 = $signed({start_i, 1'b0});
  assign terms_d.b2 = $signed({end_i, 1'b0});
  assign terms_d.d0 = DW'(end_i) - DW'(prev_i);
  assign terms_d.d1 = DW'(after_i) - DW'(start_i);

  assign cur = dly_q[crp_pkg::W_LAT-1];

  assign acc    = s01_q + s23_q;
  assign biased = acc + crp_pkg::ACC_W'(65536);

  // out of range when the bits above the sign do not all match it
  assign over = (rnd_q[crp_pkg::RND_W-1:CW-1] != '0) &&
                (rnd_q[crp_pkg::RND_W-1:CW-1] != '1);

  always_comb begin
    res_d.clip  = over;
    res_d.coord = rnd_q[CW-1:0];
    if (over) begin
      res_d.coord = rnd_q[crp_pkg::RND_W-1] ? {1'b1, {(CW-1){1'b0}}}
                                            : {1'b0, {(CW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    // hold the terms until the weights for this request arrive
    dly_q[0] <= terms_d;
    for (int i = 1; i < crp_pkg::W_LAT; i++) begin
      dly_q[i] <= dly_q[i-1];
    end
    p1_q  <= cur.a2 * weights_i.h1;
    p2_q  <= cur.b2 * weights_i.h2;
    p3_q  <= cur.d0 * weights_i.h3;
    p4_q  <= cur.d1 * weights_i.h4;
    s01_q <= crp_pkg::ACC_W'(p1_q) + crp_pkg::ACC_W'(p2_q);
    s23_q <= crp_pkg::ACC_W'(p3_q) + crp_pkg::ACC_W'(p4_q);
    rnd_q <= biased[crp_pkg::ACC_W-1:crp_pkg::FRAC_SH];
    res_q <= res_d;
  end

  assign res_o = res_q;

endmodule

FILE: src/catmull_rom_point_2d.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// catmull_rom_point_2d
// Point on a 2D Catmull-Rom segment in Q16.16, rounded and saturated.
// ----------------------------------------------------------------------------
// Fully pipelined: a request is taken on every cycle that start_i is high,
// and busy_o never rises. Each result appears on valid_o after its request
// has passed the weight unit (clamp, square, round, cube, round, weights),
// the x and y lanes (multiply, pair add, final add and round, saturate)
// and the output register. Results come in request order, one strobe per
// request, and cannot be held off by the receiver.
module catmull_rom_point_2d (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic signed [crp_pkg::COORD_W-1:0] prev_x_i,
  input  logic signed [crp_pkg::COORD_W-1:0] prev_y_i,
  input  logic signed [crp_pkg::COORD_W-1:0] start_x_i,
  input  logic signed [crp_pkg::COORD_W-1:0] start_y_i,
  input  logic signed [crp_pkg::COORD_W-1:0] end_x_i,
  input  logic signed [crp_pkg::COORD_W-1:0] end_y_i,
  input  logic signed [crp_pkg::COORD_W-1:0] after_x_i,
  input  logic signed [crp_pkg::COORD_W-1:0] after_y_i,
  input  logic        [crp_pkg::T_W-1:0]     param_t_i,
  output logic                               valid_o,
  output logic signed [crp_pkg::COORD_W-1:0] point_x_o,
  output logic signed [crp_pkg::COORD_W-1:0] point_y_o,
  output logic                               saturated_o
);

  crp_pkg::weights_t  weights;
  crp_pkg::lane_res_t res_x, res_y;

  logic [crp_pkg::OUT_LAT-1:0] vld_q, vld_d;
  logic signed [crp_pkg::COORD_W-1:0] point_x_q, point_y_q;
  logic                               sat_q;

  assign busy_o = 1'b0;

  crp_weights u_weights (
    .clk_i     (clk_i),
    .param_t_i (param_t_i),
    .weights_o (weights)
  );

  crp_lane u_lane_x (
    .clk_i     (clk_i),
    .prev_i    (prev_x_i),
    .start_i   (start_x_i),
    .end_i     (end_x_i),
    .after_i   (after_x_i),
    .weights_i (weights),
    .res_o     (res_x)
  );

  crp_lane u_lane_y (
    .clk_i     (clk_i),
    .prev_i    (prev_y_i),
    .start_i   (start_y_i),
    .end_i     (end_y_i),
    .after_i   (after_y_i),
    .weights_i (weights),
    .res_o     (res_y)
  );

  // advance the request marker alongside the data
  assign vld_d = {vld_q[crp_pkg::OUT_LAT-2:0], start_i & ~busy_o};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // merge the lanes
  always_ff @(posedge clk_i) begin
    point_x_q <= res_x.coord;
    point_y_q <= res_y.coord;
    sat_q     <= res_x.clip | res_y.clip;
  end

  assign valid_o     = vld_q[crp_pkg::OUT_LAT-1];
  assign point_x_o   = point_x_q;
  assign point_y_o   = point_y_q;
  assign saturated_o = sat_q;

endmodule
